### rtl/hmsc_pkg.sv
// Shared types, widths and codes for the height mean and spread check unit.
`timescale 1ns / 1ps

package hmsc_pkg;

    localparam int HEIGHT_W   = 32;
    localparam int LIMIT_W    = 31;
    localparam int MAX_POINTS = 65536;
    localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
    localparam int SUM_W      = HEIGHT_W + COUNT_W - 1;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_HEIGHT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 1'd1;

    // verdict codes
    localparam logic [1:0] VC_PASS        = 2'd0;
    localparam logic [1:0] VC_NO_POINTS   = 2'd1;
    localparam logic [1:0] VC_MEAN_FAR    = 2'd2;
    localparam logic [1:0] VC_SPREAD_WIDE = 2'd3;

    // accumulator snapshot of one finished cloud
    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic        [COUNT_W-1:0]  count;
        logic signed [HEIGHT_W-1:0] lowest;
        logic signed [HEIGHT_W-1:0] highest;
    } hmsc_snap_t;

    // queue status seen by the top level and the back
    typedef struct packed {
        logic full;
        logic empty;
    } hmsc_qstat_t;

endpackage

### rtl/height_mean_spread_check_unit.sv
// Top level of the height mean and spread check unit.
`timescale 1ns / 1ps

// Height mean and spread check for point clouds.
// Input: one point word (point_height, point_valid, last_point) is taken at a
// rising edge with start high and busy low. A point per cycle is sustained;
// busy rises only when both entries of the cloud queue hold finished clouds.
// Each word marked last closes a cloud: its sum, count, min and max go into a
// two-entry queue and the accumulators clear for the next cloud in the same
// cycle. An empty cloud has no valid word, its last word included.
// Output: one verdict word per cloud, on accepted, mean_height and
// verdict_code, with done high for exactly one cycle. The receiver has no way
// to stall; done drops after that cycle and the word holds until the next verdict.
// Verdict path: the closed cloud takes the queue hop, the load, a 48-step
// bit-serial division and the check before done rises.
// The back part takes a new cloud only after the last one's verdict, using the
// one-bit-a-cycle divider; clouds that close faster than it finishes back up.
// A cloud with no valid point skips the division and goes straight to the check.
// Configuration: cfg_write, cfg_index, cfg_data write robot_height (0) or
// deviation_limit (1) at a clock edge; write only while no cloud is in flight.
// Reset: rst_n clears accumulators, queue, sequencer and both registers.
module height_mean_spread_check_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [hmsc_pkg::HEIGHT_W-1:0] point_height,
    input  logic                                 point_valid,
    input  logic                                 last_point,
    output logic                                 done,
    output logic                                 accepted,
    output logic signed [hmsc_pkg::HEIGHT_W-1:0] mean_height,
    output logic        [1:0]                    verdict_code,
    input  logic                                 cfg_write,
    input  logic        [hmsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [hmsc_pkg::HEIGHT_W-1:0] cfg_data
);
    import hmsc_pkg::*;

    logic signed [HEIGHT_W-1:0] robot_height_reg,    robot_height_next;
    logic        [LIMIT_W-1:0]  deviation_limit_reg, deviation_limit_next;

    logic        take;
    logic        push;
    logic        pop;
    hmsc_snap_t  front_snap;
    hmsc_snap_t  queue_snap;
    hmsc_qstat_t qstat;

    // config registers
    always_comb
    begin
        robot_height_next    = robot_height_reg;
        deviation_limit_next = deviation_limit_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROBOT_HEIGHT:    robot_height_next    = cfg_data;
                REG_DEVIATION_LIMIT: deviation_limit_next = cfg_data[LIMIT_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_height_reg    <= '0;
            deviation_limit_reg <= '0;
        end
        else
        begin
            robot_height_reg    <= robot_height_next;
            deviation_limit_reg <= deviation_limit_next;
        end
    end

    // a point is refused only while the queue cannot take another cloud
    assign busy = qstat.full;
    assign take = start && !busy;

    hmsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .point_height (point_height),
        .point_valid  (point_valid),
        .last_point   (last_point),
        .push         (push),
        .snap         (front_snap)
    );

    hmsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_snap),
        .pop       (pop),
        .pop_data  (queue_snap),
        .stat      (qstat)
    );

    hmsc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .snap            (queue_snap),
        .qstat           (qstat),
        .pop             (pop),
        .robot_height    (robot_height_reg),
        .deviation_limit (deviation_limit_reg),
        .done            (done),
        .accepted        (accepted),
        .mean_height     (mean_height),
        .verdict_code    (verdict_code)
    );

endmodule

### rtl/hmsc_front.sv
// Front part: accumulates sum, min, max and count of valid heights per cloud.
`timescale 1ns / 1ps

module hmsc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic signed [hmsc_pkg::HEIGHT_W-1:0] point_height,
    input  logic                              point_valid,
    input  logic                              last_point,
    output logic                              push,
    output hmsc_pkg::hmsc_snap_t              snap
);
    import hmsc_pkg::*;

    logic signed [SUM_W-1:0]    sum_reg,     sum_next;
    logic        [COUNT_W-1:0]  count_reg,   count_next;
    logic signed [HEIGHT_W-1:0] lowest_reg,  lowest_next;
    logic signed [HEIGHT_W-1:0] highest_reg, highest_next;

    logic                       counts;
    logic signed [SUM_W-1:0]    height_ext;

    assign height_ext = {{(SUM_W - HEIGHT_W){point_height[HEIGHT_W-1]}}, point_height};
    // valid points past the cap are not accumulated; a last flag still closes the cloud
    assign counts = point_valid && (count_reg < COUNT_W'(MAX_POINTS));

    always_comb
    begin
        snap.sum     = sum_reg;
        snap.count   = count_reg;
        snap.lowest  = lowest_reg;
        snap.highest = highest_reg;
        if (counts)
        begin
            snap.sum   = sum_reg + height_ext;
            snap.count = count_reg + COUNT_W'(1);
            if (point_height < lowest_reg)
                snap.lowest = point_height;
            if (point_height > highest_reg)
                snap.highest = point_height;
        end
    end

    assign push = take && last_point;

    always_comb
    begin
        sum_next     = sum_reg;
        count_next   = count_reg;
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        if (take)
        begin
            if (last_point)
            begin
                sum_next     = '0;
                count_next   = '0;
                lowest_next  = {1'b0, {(HEIGHT_W - 1){1'b1}}};
                highest_next = {1'b1, {(HEIGHT_W - 1){1'b0}}};
            end
            else
            begin
                sum_next     = snap.sum;
                count_next   = snap.count;
                lowest_next  = snap.lowest;
                highest_next = snap.highest;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            count_reg   <= '0;
            lowest_reg  <= {1'b0, {(HEIGHT_W - 1){1'b1}}};
            highest_reg <= {1'b1, {(HEIGHT_W - 1){1'b0}}};
        end
        else
        begin
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            lowest_reg  <= lowest_next;
            highest_reg <= highest_next;
        end
    end

endmodule

### rtl/hmsc_queue.sv
// Two-entry queue of cloud snapshots between the front and the back.
`timescale 1ns / 1ps

module hmsc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hmsc_pkg::hmsc_snap_t push_data,
    input  logic                 pop,
    output hmsc_pkg::hmsc_snap_t pop_data,
    output hmsc_pkg::hmsc_qstat_t stat
);
    import hmsc_pkg::*;

    hmsc_snap_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg,   fill_next;
    logic        do_push, do_pop;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.empty = (fill_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 2'd1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### rtl/hmsc_back.sv
// Back part: bit-serial mean division, deviation and spread checks, verdict word.
`timescale 1ns / 1ps

module hmsc_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hmsc_pkg::hmsc_snap_t                snap,
    input  hmsc_pkg::hmsc_qstat_t               qstat,
    output logic                                pop,
    input  logic signed [hmsc_pkg::HEIGHT_W-1:0] robot_height,
    input  logic        [hmsc_pkg::LIMIT_W-1:0]  deviation_limit,
    output logic                                done,
    output logic                                accepted,
    output logic signed [hmsc_pkg::HEIGHT_W-1:0] mean_height,
    output logic        [1:0]                   verdict_code
);
    import hmsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_CHECK = 3'b100
    } state_t;

    state_t                     state_reg, state_next;
    logic        [SUM_W-1:0]    quo_reg,     quo_next;
    logic        [COUNT_W-1:0]  rem_reg,     rem_next;
    logic        [COUNT_W-1:0]  div_reg,     div_next;
    logic                       neg_reg,     neg_next;
    logic        [DIV_CNT_W-1:0] step_reg,   step_next;
    logic signed [HEIGHT_W-1:0] lowest_reg,  lowest_next;
    logic signed [HEIGHT_W-1:0] highest_reg, highest_next;
    logic                       done_reg,    done_next;
    logic                       acc_reg,     acc_next;
    logic signed [HEIGHT_W-1:0] mean_reg,    mean_next;
    logic        [1:0]          code_reg,    code_next;

    logic        [COUNT_W:0]    rem_shift;
    logic        [COUNT_W:0]    trial;
    logic        [SUM_W-1:0]    sum_mag;
    logic        [SUM_W-1:0]    quo_signed;
    logic signed [HEIGHT_W-1:0] mean_val;
    logic signed [HEIGHT_W:0]   dev;
    logic        [HEIGHT_W:0]   dev_mag;
    logic signed [HEIGHT_W:0]   spread;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign trial     = rem_shift - {1'b0, div_reg};
    assign sum_mag   = snap.sum[SUM_W-1] ? SUM_W'(-snap.sum) : SUM_W'(snap.sum);

    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign mean_val   = quo_signed[HEIGHT_W-1:0];
    assign dev        = {mean_val[HEIGHT_W-1], mean_val}
                      - {robot_height[HEIGHT_W-1], robot_height};
    assign dev_mag    = dev[HEIGHT_W] ? (~dev + (HEIGHT_W + 1)'(1)) : dev;
    assign spread     = {highest_reg[HEIGHT_W-1], highest_reg}
                      - {lowest_reg[HEIGHT_W-1], lowest_reg};

    assign pop = (state_reg == S_IDLE) && !qstat.empty;

    always_comb
    begin
        state_next   = state_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        lowest_next  = lowest_reg;
        highest_next = highest_reg;
        done_next    = 1'b0;
        acc_next     = acc_reg;
        mean_next    = mean_reg;
        code_next    = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    quo_next     = sum_mag;
                    rem_next     = '0;
                    div_next     = snap.count;
                    neg_next     = snap.sum[SUM_W-1];
                    step_next    = '0;
                    lowest_next  = snap.lowest;
                    highest_next = snap.highest;
                    if (snap.count == '0)
                        state_next = S_CHECK;
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!trial[COUNT_W])
                begin
                    rem_next = trial[COUNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[COUNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(SUM_W - 1))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                done_next = 1'b1;
                if (div_reg == '0)
                begin
                    mean_next = robot_height;
                    code_next = VC_NO_POINTS;
                end
                else
                begin
                    mean_next = mean_val;
                    if (dev_mag > {2'b00, deviation_limit})
                        code_next = VC_MEAN_FAR;
                    else if (spread > $signed({2'b00, deviation_limit}) <<< 1)
                        code_next = VC_SPREAD_WIDE;
                    else
                        code_next = VC_PASS;
                end
                acc_next   = (code_next == VC_PASS);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        neg_reg     <= neg_next;
        step_reg    <= step_next;
        lowest_reg  <= lowest_next;
        highest_reg <= highest_next;
        acc_reg     <= acc_next;
        mean_reg    <= mean_next;
        code_reg    <= code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done         = done_reg;
    assign accepted     = acc_reg;
    assign mean_height  = mean_reg;
    assign verdict_code = code_reg;

endmodule

### dv/height_mean_spread_check_unit_tb.sv
// Self-checking testbench for the height mean and spread check unit.
`timescale 1ns / 1ps

module height_mean_spread_check_unit_tb;

    import hmsc_pkg::*;

    // expected time from the last point to done; leave some slack on top
    localparam int VERDICT_LATENCY = 51;
    localparam int SETTLE_CYCLES   = VERDICT_LATENCY + 8;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_ITEMS     = 225;
    localparam int REPORT_LIMIT    = 10;

    localparam longint H_MAX   = 64'sd2147483647;
    localparam longint H_MIN   = -64'sd2147483648;
    localparam longint LIM_MAX = 64'sd2147483647;

    // one verdict word as it leaves the block
    typedef struct packed {
        logic                        ok;
        logic signed [HEIGHT_W-1:0]  mean;
        logic [1:0]                  code;
    } verdict_t;

    typedef enum logic [1:0] {
        ROW_POINT,
        ROW_SET_ROBOT,
        ROW_SET_LIMIT
    } row_kind_e;

    // directed row: a point word or a register write; typed rows carry the
    // verdict by hand, the rest go to the predictor
    typedef struct packed {
        row_kind_e         kind;
        logic [HEIGHT_W-1:0] value;
        logic              valid;
        logic              last;
        logic              typed;
        verdict_t          want;
    } stim_row_t;

    localparam int DIR_ROWS = 30;

    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        // reset config: robot height 0, limit 0
        '{ROW_POINT, 32'h0000_0000, 1'b0, 1'b1, 1'b1, '{1'b0, 32'sd0, VC_NO_POINTS}},
        '{ROW_POINT, 32'h0000_0000, 1'b1, 1'b1, 1'b1, '{1'b1, 32'sd0, VC_PASS}},
        '{ROW_POINT, 32'h0000_0001, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd1, VC_MEAN_FAR}},
        '{ROW_POINT, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h0000_0001, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd0, VC_SPREAD_WIDE}},
        '{ROW_POINT, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1,
          '{1'b0, 32'sh7fff_ffff, VC_MEAN_FAR}},
        '{ROW_POINT, 32'h8000_0000, 1'b1, 1'b1, 1'b1,
          '{1'b0, 32'sh8000_0000, VC_MEAN_FAR}},
        // sum -1 over two points truncates to zero
        '{ROW_POINT, 32'h7fff_ffff, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h8000_0000, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd0, VC_SPREAD_WIDE}},
        // -3/2 -> -1; mean and spread both off, mean check wins
        '{ROW_POINT, 32'hffff_fffd, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h0000_0000, 1'b1, 1'b1, 1'b1, '{1'b0, -32'sd1, VC_MEAN_FAR}},
        // invalid points in between and an invalid last point
        '{ROW_POINT, 32'h0000_0005, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h0000_0007, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'hffff_ffff, 1'b0, 1'b1, 1'b0, '0},
        // limits are inclusive
        '{ROW_SET_ROBOT, 32'd100, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_SET_LIMIT, 32'd10, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'd110, 1'b1, 1'b1, 1'b1, '{1'b1, 32'sd110, VC_PASS}},
        '{ROW_POINT, 32'd111, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd111, VC_MEAN_FAR}},
        '{ROW_POINT, 32'd95, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'd115, 1'b1, 1'b1, 1'b1, '{1'b1, 32'sd105, VC_PASS}},
        '{ROW_POINT, 32'd94, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'd115, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd104, VC_SPREAD_WIDE}},
        '{ROW_POINT, 32'd123, 1'b0, 1'b1, 1'b1, '{1'b0, 32'sd100, VC_NO_POINTS}},
        // widest limit: full-range spread is still one over twice the limit
        '{ROW_SET_ROBOT, 32'h0000_0000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_SET_LIMIT, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h7fff_ffff, 1'b1, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h8000_0000, 1'b1, 1'b1, 1'b1, '{1'b0, 32'sd0, VC_SPREAD_WIDE}},
        '{ROW_POINT, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1,
          '{1'b1, 32'sh7fff_ffff, VC_PASS}},
        '{ROW_SET_ROBOT, 32'h8000_0000, 1'b0, 1'b0, 1'b0, '0},
        '{ROW_POINT, 32'h7fff_ffff, 1'b1, 1'b1, 1'b1,
          '{1'b0, 32'sh7fff_ffff, VC_MEAN_FAR}}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [HEIGHT_W-1:0]    point_height = '0;
    logic                          point_valid = 1'b0;
    logic                          last_point = 1'b0;
    logic                          done;
    logic                          accepted;
    logic signed [HEIGHT_W-1:0]    mean_height;
    logic [1:0]                    verdict_code;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = '0;
    logic [HEIGHT_W-1:0]           cfg_data = '0;

    // predictor copy of the registers and of the running cloud
    longint robot_ref   = 0;
    longint dev_limit   = 0;
    longint cloud_sum   = 0;
    longint cloud_low   = H_MAX;
    longint cloud_high  = H_MIN;
    int     cloud_count = 0;

    verdict_t verdicts_due [$];
    int       verdict_errors = 0;

    height_mean_spread_check_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .point_height (point_height),
        .point_valid  (point_valid),
        .last_point   (last_point),
        .done         (done),
        .accepted     (accepted),
        .mean_height  (mean_height),
        .verdict_code (verdict_code),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Takes one accepted point word into the running cloud. Returns 1 and the
    // verdict when the word closes the cloud; the cloud then starts over.
    function automatic bit absorb_point(input logic signed [HEIGHT_W-1:0] h,
                                        input logic v, input logic l,
                                        output verdict_t vd);
        longint   hv;
        longint   avg;
        longint   off;
        logic [1:0] code;
        hv = longint'(h);
        vd = '0;
        // past MAX_POINTS valid points the cloud is frozen
        if (v && cloud_count < MAX_POINTS)
        begin
            cloud_sum += hv;
            if (hv < cloud_low)
                cloud_low = hv;
            if (hv > cloud_high)
                cloud_high = hv;
            cloud_count++;
        end
        if (!l)
            return 1'b0;
        if (cloud_count == 0)
        begin
            avg  = robot_ref;
            code = VC_NO_POINTS;
        end
        else
        begin
            // SV division truncates toward zero, as the block must
            avg = cloud_sum / longint'(cloud_count);
            off = avg - robot_ref;
            if (off < 0)
                off = -off;
            if (off > dev_limit)
                code = VC_MEAN_FAR;
            else if (cloud_high - cloud_low > 2 * dev_limit)
                code = VC_SPREAD_WIDE;
            else
                code = VC_PASS;
        end
        vd.ok   = (code == VC_PASS);
        vd.mean = avg[HEIGHT_W-1:0];
        vd.code = code;
        cloud_sum   = 0;
        cloud_low   = H_MAX;
        cloud_high  = H_MIN;
        cloud_count = 0;
        return 1'b1;
    endfunction

    // uniform-ish value in [0, span]
    function automatic longint rand_span(input longint span);
        longint unsigned r;
        r = {$urandom, $urandom};
        return $signed(r % $unsigned(span + 1));
    endfunction

    function automatic longint signed_rand(input longint span);
        return rand_span(2 * span) - span;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] clamp_height(input longint x);
        if (x > H_MAX)
            return H_MAX[HEIGHT_W-1:0];
        if (x < H_MIN)
            return H_MIN[HEIGHT_W-1:0];
        return x[HEIGHT_W-1:0];
    endfunction

    // Offers one point word after an idle gap set by gap and holds it until taken.
    // start is left high so a back-to-back word need not raise it again.
    task automatic send_point(input int gap, input logic signed [HEIGHT_W-1:0] h,
                              input logic v, input logic l,
                              input logic typed, input verdict_t want);
        verdict_t model_vd;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        point_height <= h;
        point_valid  <= v;
        last_point   <= l;
        do
            @(posedge clk);
        while (busy);
        if (absorb_point(h, v, l, model_vd))
            verdicts_due.push_back(typed ? want : model_vd);
    endtask

    // Stops the sender until every verdict is in, then idles for the given tail.
    // Always waits on a clock edge first so start never sees two writes in a step.
    task automatic drain_verdicts(input int tail);
        start <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [HEIGHT_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == REG_ROBOT_HEIGHT)
            robot_ref = longint'($signed(val));
        else
            dev_limit = longint'({1'b0, val[LIMIT_W-1:0]});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Verdict checker: done is a one-cycle strobe, sampled at the edge that
    // ends its cycle; the oldest expectation must match every field.
    always @(posedge clk)
    begin : check_verdicts
        verdict_t want;
        verdict_t got;
        if (rst_n && done)
        begin
            got = '{accepted, mean_height, verdict_code};
            if (verdicts_due.size() == 0)
            begin
                verdict_errors++;
                if (verdict_errors <= REPORT_LIMIT)
                    $display("%0t: unexpected verdict word acc=%0d mean=%0d code=%0d",
                             $realtime, got.ok, got.mean, got.code);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (got.ok !== want.ok || got.mean !== want.mean
                    || got.code !== want.code)
                begin
                    verdict_errors++;
                    if (verdict_errors <= REPORT_LIMIT)
                        $display({"%0t: verdict mismatch, expected acc=%0d mean=%0d ",
                                  "code=%0d, got acc=%0d mean=%0d code=%0d"},
                                 $realtime, want.ok, want.mean, want.code,
                                 got.ok, got.mean, got.code);
                end
            end
        end
    end

    initial
    begin : stimulus
        int     k;
        int     phase;
        int     counted;
        int     len;
        int     shape;
        bit     burst;
        logic   v;
        longint center;
        longint half;
        longint robot_pick;
        longint lim_pick;
        logic signed [HEIGHT_W-1:0] h;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; register rows wait for the pipe to empty first
        for (k = 0; k < DIR_ROWS; k++)
        begin
            case (dir_rows[k].kind)
                ROW_SET_ROBOT:
                begin
                    drain_verdicts(SETTLE_CYCLES);
                    program_reg(REG_ROBOT_HEIGHT, dir_rows[k].value);
                end
                ROW_SET_LIMIT:
                begin
                    drain_verdicts(SETTLE_CYCLES);
                    program_reg(REG_DEVIATION_LIMIT, dir_rows[k].value);
                end
                default:
                    send_point($urandom_range(0, 17), dir_rows[k].value,
                               dir_rows[k].valid, dir_rows[k].last,
                               dir_rows[k].typed, dir_rows[k].want);
            endcase
        end

        // Point cap: MAX_POINTS small heights, then full-range valid points
        // that must be dropped. Had they counted, the spread check would trip.
        drain_verdicts(SETTLE_CYCLES);
        program_reg(REG_ROBOT_HEIGHT, '0);
        program_reg(REG_DEVIATION_LIMIT, LIM_MAX[HEIGHT_W-1:0]);
        for (k = 0; k < MAX_POINTS; k++)
            send_point(0, clamp_height(signed_rand(64'sd1 << 20)), 1'b1, 1'b0,
                       1'b0, '0);
        send_point(0, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b0, '0);
        send_point(0, 32'sh8000_0000, 1'b1, 1'b0, 1'b0, '0);
        send_point(3, 32'sh7fff_ffff, 1'b1, 1'b0, 1'b0, '0);
        send_point(0, 32'sh8000_0000, 1'b1, 1'b1, 1'b0, '0);

        // Random phases, each under its own register setting. Clouds are mostly
        // shaped around the robot height so all verdicts come up.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            drain_verdicts(SETTLE_CYCLES);
            case (phase)
                0:
                begin
                    robot_pick = H_MAX;
                    lim_pick   = 0;
                end
                1:
                begin
                    robot_pick = H_MIN;
                    lim_pick   = LIM_MAX;
                end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       robot_pick = 0;
                        1:       robot_pick = signed_rand(64'sd1 << 22);
                        2:       robot_pick = ($urandom_range(0, 1)) ? H_MAX : H_MIN;
                        default: robot_pick = longint'($signed($urandom));
                    endcase
                    case ($urandom_range(0, 4))
                        0:       lim_pick = 0;
                        1:       lim_pick = LIM_MAX;
                        2:       lim_pick = rand_span(64'sd1 << 16);
                        3:       lim_pick = rand_span(64'sd1 << 24);
                        default: lim_pick = rand_span(LIM_MAX);
                    endcase
                end
            endcase
            program_reg(REG_ROBOT_HEIGHT, robot_pick[HEIGHT_W-1:0]);
            program_reg(REG_DEVIATION_LIMIT, {1'b0, lim_pick[LIMIT_W-1:0]});

            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                // now and then let the back end run dry
                if ($urandom_range(0, 24) == 0)
                    drain_verdicts(0);
                // shape 0: all invalid, 1..3: full-range heights, else near
                shape  = $urandom_range(0, 11);
                len    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                     : $urandom_range(1, 12);
                burst  = ($urandom_range(0, 3) == 0);
                center = robot_ref + signed_rand(dev_limit + dev_limit / 2 + 4);
                half   = rand_span(dev_limit + dev_limit / 4 + 2);
                for (k = 0; k < len; k++)
                begin
                    v = (shape != 0) && ($urandom_range(0, 7) != 0);
                    if (shape <= 3)
                        h = $urandom;
                    else
                        h = clamp_height(center + signed_rand(half));
                    send_point(burst ? 0 : $urandom_range(0, 17), h, v,
                               k == len - 1, 1'b0, '0);
                    if (v || k == len - 1)
                        counted++;
                end
            end
        end

        drain_verdicts(SETTLE_CYCLES);
        if (verdict_errors == 0 && verdicts_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
